@@ rtl/core/msdspi_pkg.sv @@
`default_nettype none

package msdspi_pkg;

  // Command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Device codes
  localparam logic [1:0] DEV_ADC = 2'd0;
  localparam logic [1:0] DEV_DAC = 2'd1;
  localparam logic [1:0] DEV_CLK = 2'd2;

  // Frame kinds: write kinds first, read kinds = device + 3
  localparam logic [2:0] KIND_ADC_WR = 3'd0;
  localparam logic [2:0] KIND_DAC_WR = 3'd1;
  localparam logic [2:0] KIND_CLK_WR = 3'd2;
  localparam logic [2:0] KIND_ADC_RD = 3'd3;
  localparam logic [2:0] KIND_DAC_RD = 3'd4;
  localparam logic [2:0] KIND_CLK_RD = 3'd5;
  localparam logic [2:0] KIND_RD_BASE = 3'd3;

  localparam int unsigned FRAME_W = 24;
  localparam logic [4:0] DATA_BITS = 5'd8;
  localparam logic [7:0] HALF_PERIOD_RST = 8'd10;

  // Select vector: bit0 adc1, bit1 adc2, bit2 dac1, bit3 dac2, bit4 clk
  localparam logic [4:0] SEL_IDLE   = 5'h1F;
  localparam logic [4:0] SEL_ADC    = 5'h1C;
  localparam logic [4:0] SEL_DAC    = 5'h13;
  localparam logic [4:0] SEL_CLK    = 5'h0F;
  localparam logic [4:0] SEL_ADC1   = 5'h1E;
  localparam logic [4:0] SEL_ADC2   = 5'h1D;
  localparam logic [4:0] SEL_DAC1   = 5'h1B;
  localparam logic [4:0] SEL_DAC2   = 5'h17;

  typedef struct packed {
    logic [FRAME_W-1:0] shift;
    logic [2:0]         kind;
    logic [4:0]         sel_n;
  } frame_load_t;

  // Number of bits shifted out for each frame kind
  function automatic logic [4:0] out_len(input logic [2:0] kind);
    logic [4:0] len;
    case (kind)
      KIND_DAC_WR, KIND_ADC_RD, KIND_CLK_RD: len = 5'd16;
      KIND_DAC_RD:                           len = 5'd8;
      default:                               len = 5'd24;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/msdspi_if.sv @@
`default_nettype none

// Command beat channel
interface msdspi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [1:0]  device;
  logic        chip_pick;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic        serial_in;

  modport source (output valid, command, device, chip_pick, address, write_data, serial_in,
                  input ready);
  modport sink   (input valid, command, device, chip_pick, address, write_data, serial_in,
                  output ready);
endinterface

// Pin-level result beat channel
interface msdspi_out_if;
  logic       valid;
  logic       ready;
  logic       sclk;
  logic       mosi;
  logic       sdio_drive;
  logic       adc_sel1_n;
  logic       adc_sel2_n;
  logic       dac_sel1_n;
  logic       dac_sel2_n;
  logic       clk_sel_n;
  logic       busy_res;
  logic       read_valid;
  logic [7:0] read_data;
  logic       rejected;

  modport source (output valid, sclk, mosi, sdio_drive, adc_sel1_n, adc_sel2_n, dac_sel1_n,
                  dac_sel2_n, clk_sel_n, busy_res, read_valid, read_data, rejected,
                  input ready);
  modport sink   (input valid, sclk, mosi, sdio_drive, adc_sel1_n, adc_sel2_n, dac_sel1_n,
                  dac_sel2_n, clk_sel_n, busy_res, read_valid, read_data, rejected,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/msdspi_frame.sv @@
`default_nettype none

// Builds the left-aligned shift word, kind and selects for a new frame
module msdspi_frame
  import msdspi_pkg::*;
(
  input  wire logic        rd_i,
  input  wire logic [1:0]  device_i,
  input  wire logic        chip_pick_i,
  input  wire logic [15:0] address_i,
  input  wire logic [7:0]  write_data_i,
  output frame_load_t      load_o
);

  logic [2:0] kind;

  assign kind = {1'b0, device_i} + (rd_i ? KIND_RD_BASE : 3'd0);

  always_comb begin
    load_o.kind = kind;
    case (kind)
      KIND_ADC_WR: begin
        load_o.shift = {8'h00, address_i[7:0], write_data_i};
        load_o.sel_n = SEL_ADC;
      end
      KIND_DAC_WR: begin
        load_o.shift = {address_i[7:0], write_data_i, 8'h00};
        load_o.sel_n = SEL_DAC;
      end
      KIND_CLK_WR: begin
        load_o.shift = {address_i, write_data_i};
        load_o.sel_n = SEL_CLK;
      end
      KIND_ADC_RD: begin
        // read bit on top of the 16-bit instruction
        load_o.shift = {8'h80, address_i[7:0], 8'h00};
        load_o.sel_n = chip_pick_i ? SEL_ADC2 : SEL_ADC1;
      end
      KIND_DAC_RD: begin
        load_o.shift = {1'b1, address_i[6:0], 16'h0000};
        load_o.sel_n = chip_pick_i ? SEL_DAC2 : SEL_DAC1;
      end
      default: begin
        load_o.shift = {1'b1, address_i[14:0], 8'h00};
        load_o.sel_n = SEL_CLK;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/multi_device_spi_master_top.sv @@
`default_nettype none

// Channel  | Dir | Beat
// ---------+-----+-------------------------------------------------------
// in_if    | in  | one system tick: command, device, pick, address, data, serial_in
// out_if   | out | pin levels after that tick, read byte, busy, reject
// cfg      | in  | cfg_we_i / cfg_wdata_i write half_period, no read-back
//
// One input beat per clock; each beat updates the sequencer in the same cycle
// and its result sits in the output register the cycle after.
// in_if.ready drops only while the output register is full and out_if.ready is
// low; the sequencer advances only on accepted beats, so stalls lose no tick.
// Reset (rst_ni low) releases all selects, idles the clock, half_period = 10.
module multi_device_spi_master_top
  import msdspi_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  msdspi_in_if.sink       in_if,
  msdspi_out_if.source    out_if
);

  // Sequencer state
  logic [FRAME_W-1:0] out_shift_q, out_shift_d;
  logic [7:0]         in_shift_q, in_shift_d;
  logic [4:0]         bit_count_q, bit_count_d;
  logic [7:0]         tick_count_q, tick_count_d;
  logic               clock_high_q, clock_high_d;
  logic [2:0]         frame_kind_q, frame_kind_d;
  logic               data_phase_q, data_phase_d;
  logic [4:0]         sel_n_q, sel_n_d;
  logic               active_q, active_d;
  logic [7:0]         half_period_q;

  // Result register
  logic       res_valid_q;
  logic       res_sclk_q, res_mosi_q, res_sdio_q;
  logic [4:0] res_sel_n_q;
  logic       res_busy_q, res_rvalid_q, res_rejected_q;
  logic [7:0] res_rdata_q;

  logic        in_fire, start, is_read_kind;
  logic [7:0]  hp, tick_inc;
  logic [4:0]  bit_inc, limit;
  logic        rd_valid, rejected;
  logic [7:0]  rd_data;
  frame_load_t load;

  assign in_if.ready = !res_valid_q || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;
  assign start       = (in_if.command == CMD_WRITE) || (in_if.command == CMD_READ);
  assign hp          = (half_period_q == 8'd0) ? 8'd1 : half_period_q;
  assign tick_inc    = tick_count_q + 8'd1;
  assign bit_inc     = bit_count_q + 5'd1;
  assign limit       = data_phase_q ? DATA_BITS : out_len(frame_kind_q);
  assign is_read_kind = frame_kind_q >= KIND_RD_BASE;

  msdspi_frame u_frame (
    .rd_i         (in_if.command == CMD_READ),
    .device_i     (in_if.device),
    .chip_pick_i  (in_if.chip_pick),
    .address_i    (in_if.address),
    .write_data_i (in_if.write_data),
    .load_o       (load)
  );

  // Next state for one tick
  always_comb begin
    out_shift_d  = out_shift_q;
    in_shift_d   = in_shift_q;
    bit_count_d  = bit_count_q;
    tick_count_d = tick_count_q;
    clock_high_d = clock_high_q;
    frame_kind_d = frame_kind_q;
    data_phase_d = data_phase_q;
    sel_n_d      = sel_n_q;
    active_d     = active_q;
    rd_valid     = 1'b0;
    rd_data      = 8'h00;
    rejected     = 1'b0;
    if (in_fire) begin
      if (active_q) begin
        rejected = start;
        if (tick_inc < hp) begin
          tick_count_d = tick_inc;
        end else begin
          tick_count_d = 8'd0;
          if (!clock_high_q) begin
            // rising edge: sample return data in the data phase
            clock_high_d = 1'b1;
            if (data_phase_q) in_shift_d = {in_shift_q[6:0], in_if.serial_in};
          end else begin
            // falling edge: next bit
            clock_high_d = 1'b0;
            if (!data_phase_q) out_shift_d = {out_shift_q[FRAME_W-2:0], 1'b0};
            if (bit_inc < limit) begin
              bit_count_d = bit_inc;
            end else begin
              bit_count_d = 5'd0;
              if (!data_phase_q && is_read_kind) begin
                data_phase_d = 1'b1;
              end else begin
                if (is_read_kind) begin
                  rd_valid = 1'b1;
                  rd_data  = in_shift_q;
                end
                active_d     = 1'b0;
                data_phase_d = 1'b0;
                sel_n_d      = SEL_IDLE;
                out_shift_d  = '0;
              end
            end
          end
        end
      end else if (start && in_if.device <= DEV_CLK) begin
        out_shift_d  = load.shift;
        frame_kind_d = load.kind;
        sel_n_d      = load.sel_n;
        in_shift_d   = 8'h00;
        bit_count_d  = 5'd0;
        tick_count_d = 8'd0;
        clock_high_d = 1'b0;
        data_phase_d = 1'b0;
        active_d     = 1'b1;
      end
    end
  end

  // State, config and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_shift_q    <= '0;
      in_shift_q     <= 8'h00;
      bit_count_q    <= 5'd0;
      tick_count_q   <= 8'd0;
      clock_high_q   <= 1'b0;
      frame_kind_q   <= KIND_ADC_WR;
      data_phase_q   <= 1'b0;
      sel_n_q        <= SEL_IDLE;
      active_q       <= 1'b0;
      half_period_q  <= HALF_PERIOD_RST;
      res_valid_q    <= 1'b0;
    end else begin
      out_shift_q    <= out_shift_d;
      in_shift_q     <= in_shift_d;
      bit_count_q    <= bit_count_d;
      tick_count_q   <= tick_count_d;
      clock_high_q   <= clock_high_d;
      frame_kind_q   <= frame_kind_d;
      data_phase_q   <= data_phase_d;
      sel_n_q        <= sel_n_d;
      active_q       <= active_d;
      if (cfg_we_i) half_period_q <= cfg_wdata_i;
      if (in_fire) begin
        res_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted beat
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_sclk_q     <= clock_high_d;
      res_mosi_q     <= active_d && !data_phase_d && out_shift_d[FRAME_W-1];
      res_sdio_q     <= !(active_d && data_phase_d && frame_kind_d == KIND_ADC_RD);
      res_sel_n_q    <= sel_n_d;
      res_busy_q     <= active_d;
      res_rvalid_q   <= rd_valid;
      res_rdata_q    <= rd_data;
      res_rejected_q <= rejected;
    end
  end

  assign out_if.valid      = res_valid_q;
  assign out_if.sclk       = res_sclk_q;
  assign out_if.mosi       = res_mosi_q;
  assign out_if.sdio_drive = res_sdio_q;
  assign out_if.adc_sel1_n = res_sel_n_q[0];
  assign out_if.adc_sel2_n = res_sel_n_q[1];
  assign out_if.dac_sel1_n = res_sel_n_q[2];
  assign out_if.dac_sel2_n = res_sel_n_q[3];
  assign out_if.clk_sel_n  = res_sel_n_q[4];
  assign out_if.busy_res   = res_busy_q;
  assign out_if.read_valid = res_rvalid_q;
  assign out_if.read_data  = res_rdata_q;
  assign out_if.rejected   = res_rejected_q;

  // Idle sequencer keeps every chip deselected
  a_idle_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> sel_n_q == SEL_IDLE)
    else $error("selects asserted while idle");

  // Serial clock is low whenever no frame runs
  a_idle_sclk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> !clock_high_q)
    else $error("sclk high while idle");

  // Only read frames enter a data phase
  a_data_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_phase_q |-> (active_q && frame_kind_q >= KIND_RD_BASE))
    else $error("data phase outside a read frame");

  // A completed read ends the frame in the same beat
  a_read_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_rvalid_q) |-> !res_busy_q)
    else $error("read_valid while still busy");

endmodule

`default_nettype wire
